>>> hw/rtl/sle_pkg.sv
// Package for the SIMT lane execute stage: operation codes, decoded control
// and execute result types, and fixed sizes. No dependencies.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned HALF_BYTES  = WORD_BYTES / 2;
  localparam int unsigned INSN_BYTES  = 4;
  localparam int unsigned UPPER_SHIFT = 12;

  localparam logic [5:0] FN_ADDI  = 6'd0;
  localparam logic [5:0] FN_ADD   = 6'd1;
  localparam logic [5:0] FN_SUB   = 6'd2;
  localparam logic [5:0] FN_AND   = 6'd3;
  localparam logic [5:0] FN_ANDI  = 6'd4;
  localparam logic [5:0] FN_OR    = 6'd5;
  localparam logic [5:0] FN_ORI   = 6'd6;
  localparam logic [5:0] FN_XOR   = 6'd7;
  localparam logic [5:0] FN_XORI  = 6'd8;
  localparam logic [5:0] FN_SLL   = 6'd9;
  localparam logic [5:0] FN_SLLI  = 6'd10;
  localparam logic [5:0] FN_SRL   = 6'd11;
  localparam logic [5:0] FN_SRLI  = 6'd12;
  localparam logic [5:0] FN_SRA   = 6'd13;
  localparam logic [5:0] FN_SRAI  = 6'd14;
  localparam logic [5:0] FN_LUI   = 6'd15;
  localparam logic [5:0] FN_AUIPC = 6'd16;
  localparam logic [5:0] FN_LW    = 6'd17;
  localparam logic [5:0] FN_LH    = 6'd18;
  localparam logic [5:0] FN_LHU   = 6'd19;
  localparam logic [5:0] FN_LB    = 6'd20;
  localparam logic [5:0] FN_SW    = 6'd21;
  localparam logic [5:0] FN_SH    = 6'd22;
  localparam logic [5:0] FN_SB    = 6'd23;
  localparam logic [5:0] FN_JAL   = 6'd24;
  localparam logic [5:0] FN_JALR  = 6'd25;
  localparam logic [5:0] FN_BEQ   = 6'd26;
  localparam logic [5:0] FN_BNE   = 6'd27;
  localparam logic [5:0] FN_BLT   = 6'd28;
  localparam logic [5:0] FN_BLTU  = 6'd29;
  localparam logic [5:0] FN_BGE   = 6'd30;
  localparam logic [5:0] FN_BGEU  = 6'd31;
  localparam logic [5:0] FN_ECALL = 6'd32;
  localparam logic [5:0] FN_EBRK  = 6'd33;
  localparam logic [5:0] FN_CSRRW = 6'd34;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'(HALF_BYTES);
  localparam logic [2:0] SIZE_WORD = 3'(WORD_BYTES);

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_SLL,
    ALU_SRL,
    ALU_SRA,
    ALU_LUI,
    ALU_AUIPC,
    ALU_LINK
  } alu_op_t;

  typedef enum logic [2:0] {
    BR_EQ,
    BR_NE,
    BR_LT,
    BR_LTU,
    BR_GE,
    BR_GEU
  } br_cond_t;

  typedef struct packed {
    alu_op_t    alu_op;
    logic       use_imm;
    logic [1:0] mem_req;
    logic [2:0] mem_bytes;
    logic       mem_uns;
    logic       branch;
    br_cond_t   cond;
    logic       jal;
    logic       jalr;
    logic       wen;
    logic       wb;
    logic       unsupported;
  } ctrl_t;

  typedef struct packed {
    logic [31:0] wval;
    logic [31:0] sum_ai;
    logic [31:0] pc_imm;
    logic [31:0] pc_4;
    logic [31:0] sdata;
    logic        taken;
  } exe_t;

endpackage

>>> hw/rtl/sle_decode.sv
// Operation code decoder for the lane execute stage.
// Depends on sle_pkg for the codes and the control struct.
`timescale 1ns / 1ps

module sle_decode (
  input  logic [5:0]     func,
  output sle_pkg::ctrl_t ctrl
);
  import sle_pkg::*;

  always_comb begin
    ctrl             = '0;
    ctrl.alu_op      = ALU_NONE;
    ctrl.cond        = BR_EQ;
    ctrl.mem_req     = MEM_NONE;
    ctrl.mem_bytes   = SIZE_NONE;
    case (func)
      FN_ADDI:  begin ctrl.alu_op = ALU_ADD;   ctrl.use_imm = 1'b1; end
      FN_ADD:   ctrl.alu_op = ALU_ADD;
      FN_SUB:   ctrl.alu_op = ALU_SUB;
      FN_AND:   ctrl.alu_op = ALU_AND;
      FN_ANDI:  begin ctrl.alu_op = ALU_AND;   ctrl.use_imm = 1'b1; end
      FN_OR:    ctrl.alu_op = ALU_OR;
      FN_ORI:   begin ctrl.alu_op = ALU_OR;    ctrl.use_imm = 1'b1; end
      FN_XOR:   ctrl.alu_op = ALU_XOR;
      FN_XORI:  begin ctrl.alu_op = ALU_XOR;   ctrl.use_imm = 1'b1; end
      FN_SLL:   ctrl.alu_op = ALU_SLL;
      FN_SLLI:  begin ctrl.alu_op = ALU_SLL;   ctrl.use_imm = 1'b1; end
      FN_SRL:   ctrl.alu_op = ALU_SRL;
      FN_SRLI:  begin ctrl.alu_op = ALU_SRL;   ctrl.use_imm = 1'b1; end
      FN_SRA:   ctrl.alu_op = ALU_SRA;
      FN_SRAI:  begin ctrl.alu_op = ALU_SRA;   ctrl.use_imm = 1'b1; end
      FN_LUI:   ctrl.alu_op = ALU_LUI;
      FN_AUIPC: ctrl.alu_op = ALU_AUIPC;
      FN_LW:    begin ctrl.mem_req = MEM_LOAD;  ctrl.mem_bytes = SIZE_WORD; end
      FN_LH:    begin ctrl.mem_req = MEM_LOAD;  ctrl.mem_bytes = SIZE_HALF; end
      FN_LHU:   begin
        ctrl.mem_req   = MEM_LOAD;
        ctrl.mem_bytes = SIZE_HALF;
        ctrl.mem_uns   = 1'b1;
      end
      FN_LB:    begin ctrl.mem_req = MEM_LOAD;  ctrl.mem_bytes = SIZE_BYTE; end
      FN_SW:    begin ctrl.mem_req = MEM_STORE; ctrl.mem_bytes = SIZE_WORD; end
      FN_SH:    begin ctrl.mem_req = MEM_STORE; ctrl.mem_bytes = SIZE_HALF; end
      FN_SB:    begin ctrl.mem_req = MEM_STORE; ctrl.mem_bytes = SIZE_BYTE; end
      FN_JAL:   begin ctrl.alu_op = ALU_LINK;  ctrl.jal  = 1'b1; end
      FN_JALR:  begin ctrl.alu_op = ALU_LINK;  ctrl.jalr = 1'b1; end
      FN_BEQ:   begin ctrl.branch = 1'b1; ctrl.cond = BR_EQ;  end
      FN_BNE:   begin ctrl.branch = 1'b1; ctrl.cond = BR_NE;  end
      FN_BLT:   begin ctrl.branch = 1'b1; ctrl.cond = BR_LT;  end
      FN_BLTU:  begin ctrl.branch = 1'b1; ctrl.cond = BR_LTU; end
      FN_BGE:   begin ctrl.branch = 1'b1; ctrl.cond = BR_GE;  end
      FN_BGEU:  begin ctrl.branch = 1'b1; ctrl.cond = BR_GEU; end
      FN_ECALL, FN_EBRK, FN_CSRRW: ctrl.alu_op = ALU_NONE;
      default:  ctrl.unsupported = 1'b1;
    endcase
    ctrl.wen = (ctrl.alu_op != ALU_NONE);
    ctrl.wb  = ctrl.wen || ctrl.branch;
  end

endmodule

>>> hw/rtl/sle_alu.sv
// Arithmetic, shift, address and branch compare logic of the lane execute stage.
// Depends on sle_pkg for the control and result structs.
`timescale 1ns / 1ps

module sle_alu (
  input  sle_pkg::ctrl_t ctrl,
  input  logic [31:0]    a,
  input  logic [31:0]    b,
  input  logic [31:0]    imm,
  input  logic [31:0]    pc,
  output sle_pkg::exe_t  res
);
  import sle_pkg::*;

  logic [31:0] opb;
  logic [4:0]  amt;
  logic [31:0] upper;
  logic [31:0] value;

  assign opb   = ctrl.use_imm ? imm : b;
  assign amt   = opb[4:0];
  assign upper = imm << UPPER_SHIFT;

  always_comb begin
    res        = '0;
    res.sum_ai = a + imm;
    res.pc_imm = pc + imm;
    res.pc_4   = pc + 32'(INSN_BYTES);
    case (ctrl.alu_op)
      ALU_ADD:   value = a + opb;
      ALU_SUB:   value = a - opb;
      ALU_AND:   value = a & opb;
      ALU_OR:    value = a | opb;
      ALU_XOR:   value = a ^ opb;
      ALU_SLL:   value = a << amt;
      ALU_SRL:   value = a >> amt;
      ALU_SRA:   value = $unsigned($signed(a) >>> amt);
      ALU_LUI:   value = upper;
      ALU_AUIPC: value = pc + upper;
      ALU_LINK:  value = pc + 32'(INSN_BYTES);
      default:   value = '0;
    endcase
    res.wval = ctrl.wen ? value : '0;
    case (ctrl.cond)
      BR_EQ:   res.taken = (a == b);
      BR_NE:   res.taken = (a != b);
      BR_LT:   res.taken = ($signed(a) < $signed(b));
      BR_LTU:  res.taken = (a < b);
      BR_GE:   res.taken = !($signed(a) < $signed(b));
      BR_GEU:  res.taken = !(a < b);
      default: res.taken = 1'b0;
    endcase
    if (ctrl.mem_req == MEM_STORE) begin
      case (ctrl.mem_bytes)
        SIZE_BYTE: res.sdata = {24'd0, b[7:0]};
        SIZE_HALF: res.sdata = {16'd0, b[15:0]};
        default:   res.sdata = b;
      endcase
    end
  end

endmodule

>>> hw/rtl/simt_lane_rv32i_execute.sv
// Top level of the SIMT lane execute stage: three register stages with
// decode, execute and result selection. Depends on sle_pkg, sle_decode, sle_alu.
//
//   channel  | handshake                   | payload
//   item     | item_valid / item_stall     | func .. last_lane
//   result   | result_valid / result_stall | write_value .. last_out
//
// An accepted beat moves through the s1 register, the s2 register and the result
// register in that order. One beat can enter every cycle while item_stall is low.
// Reset clears the valid bit of every stage; payload registers are not reset.
// A stage holds while its successor is full and stalled, so a stall on the
// result side backs up through empty slots before item_stall rises.
`timescale 1ns / 1ps

module simt_lane_rv32i_execute (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [5:0]         func,
  input  logic signed [31:0] first_value,
  input  logic signed [31:0] second_value,
  input  logic signed [31:0] immediate,
  input  logic [31:0]        lane_pc,
  input  logic [4:0]         dest_index,
  input  logic               last_lane,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        write_value,
  output logic               write_enable,
  output logic [4:0]         write_index,
  output logic [31:0]        next_pc,
  output logic [1:0]         mem_request,
  output logic [31:0]        mem_address,
  output logic [2:0]         mem_bytes,
  output logic               mem_unsigned,
  output logic [31:0]        store_data,
  output logic               status,
  output logic               writeback_needed,
  output logic               last_out
);
  import sle_pkg::*;

  ctrl_t       dec_ctrl;
  exe_t        alu_res;

  logic        s1_valid;
  ctrl_t       s1_ctrl;
  logic [31:0] s1_a;
  logic [31:0] s1_b;
  logic [31:0] s1_imm;
  logic [31:0] s1_pc;
  logic [4:0]  s1_rd;
  logic        s1_last;

  logic        s2_valid;
  ctrl_t       s2_ctrl;
  exe_t        s2_res;
  logic [4:0]  s2_rd;
  logic        s2_last;

  logic        ready1;
  logic        ready2;
  logic        ready3;
  logic [31:0] npc_next;

  assign ready3     = !result_valid || !result_stall;
  assign ready2     = !s2_valid || ready3;
  assign ready1     = !s1_valid || ready2;
  assign item_stall = !ready1;

  sle_decode u_decode (
    .func (func),
    .ctrl (dec_ctrl)
  );

  sle_alu u_alu (
    .ctrl (s1_ctrl),
    .a    (s1_a),
    .b    (s1_b),
    .imm  (s1_imm),
    .pc   (s1_pc),
    .res  (alu_res)
  );

  always_comb begin
    if (s2_ctrl.jal || (s2_ctrl.branch && s2_res.taken)) begin
      npc_next = s2_res.pc_imm;
    end else if (s2_ctrl.jalr) begin
      npc_next = {s2_res.sum_ai[31:1], 1'b0};
    end else begin
      npc_next = s2_res.pc_4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) s1_valid <= item_valid;
      if (ready2) s2_valid <= s1_valid;
      if (ready3) result_valid <= s2_valid;
    end
    if (ready1 && item_valid) begin
      s1_ctrl <= dec_ctrl;
      s1_a    <= $unsigned(first_value);
      s1_b    <= $unsigned(second_value);
      s1_imm  <= $unsigned(immediate);
      s1_pc   <= lane_pc;
      s1_rd   <= dest_index;
      s1_last <= last_lane;
    end
    if (ready2 && s1_valid) begin
      s2_ctrl <= s1_ctrl;
      s2_res  <= alu_res;
      s2_rd   <= s1_rd;
      s2_last <= s1_last;
    end
    if (ready3 && s2_valid) begin
      write_value      <= s2_res.wval;
      write_enable     <= s2_ctrl.wen;
      write_index      <= s2_rd;
      next_pc          <= npc_next;
      mem_request      <= s2_ctrl.mem_req;
      mem_address      <= (s2_ctrl.mem_req != MEM_NONE) ? s2_res.sum_ai : '0;
      mem_bytes        <= s2_ctrl.mem_bytes;
      mem_unsigned     <= s2_ctrl.mem_uns;
      store_data       <= s2_res.sdata;
      status           <= s2_ctrl.unsupported;
      writeback_needed <= s2_ctrl.wb;
      last_out         <= s2_last;
    end
  end

endmodule

>>> hw/rtl/sle_checker.sv
// Port-level checks for the SIMT lane execute stage, bound to its top level.
// Depends on the top level's ports and on sle_pkg for the memory request codes.
`timescale 1ns / 1ps

module sle_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic       write_enable,
  input logic       writeback_needed,
  input logic [1:0] mem_request,
  input logic       status
);
  import sle_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");

  a_unsupported: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> !write_enable && mem_request == MEM_NONE
      && !writeback_needed)
    else $error("unsupported beat has side effects");

  a_mem_no_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && mem_request != MEM_NONE |-> !write_enable && !writeback_needed
      && (mem_request == MEM_LOAD || mem_request == MEM_STORE))
    else $error("memory beat also writes a register");

  a_write_wb: assert property (@(posedge clk) disable iff (rst)
    result_valid && write_enable |-> writeback_needed && !status)
    else $error("register write without writeback flag");

endmodule

bind simt_lane_rv32i_execute sle_checker u_sle_checker (.*);

>>> verif/simt_lane_rv32i_execute_tb.sv
// Self-checking testbench for simt_lane_rv32i_execute: directed corner beats, then random
// lane operations with random idling on both channels, checked against a lane predictor.
// Depends on sle_pkg and the simt_lane_rv32i_execute RTL.
`timescale 1ns / 1ps

module simt_lane_rv32i_execute_tb;
  import sle_pkg::*;

  localparam logic [5:0] FN_FIRST_UNSUPPORTED = FN_CSRRW + 6'd1;
  localparam logic [5:0] FN_MAX = 6'h3F;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BEATS = 900;

  typedef struct packed {
    logic [5:0]  func;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [31:0] immediate;
    logic [31:0] lane_pc;
    logic [4:0]  dest_index;
    logic        last_lane;
  } lane_op_t;

  typedef struct packed {
    logic [31:0] write_value;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] next_pc;
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [2:0]  mem_bytes;
    logic        mem_unsigned;
    logic [31:0] store_data;
    logic        status;
    logic        writeback_needed;
    logic        last_out;
  } lane_result_t;

  class lane_scoreboard;
    lane_result_t expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function lane_result_t execute_lane(lane_op_t op);
      lane_result_t r;
      logic [31:0] a, b, imm, pc, wval;
      logic taken;
      a = op.first_value;
      b = op.second_value;
      imm = op.immediate;
      pc = op.lane_pc;
      r = '0;
      wval = '0;
      taken = 1'b0;
      r.write_index = op.dest_index;
      r.last_out = op.last_lane;
      r.next_pc = pc + INSN_BYTES;
      case (op.func)
        FN_ADDI:  wval = a + imm;
        FN_ADD:   wval = a + b;
        FN_SUB:   wval = a - b;
        FN_AND:   wval = a & b;
        FN_ANDI:  wval = a & imm;
        FN_OR:    wval = a | b;
        FN_ORI:   wval = a | imm;
        FN_XOR:   wval = a ^ b;
        FN_XORI:  wval = a ^ imm;
        FN_SLL:   wval = a << b[4:0];
        FN_SLLI:  wval = a << imm[4:0];
        FN_SRL:   wval = a >> b[4:0];
        FN_SRLI:  wval = a >> imm[4:0];
        FN_SRA:   wval = $signed(a) >>> b[4:0];
        FN_SRAI:  wval = $signed(a) >>> imm[4:0];
        FN_LUI:   wval = imm << UPPER_SHIFT;
        FN_AUIPC: wval = pc + (imm << UPPER_SHIFT);
        FN_LW, FN_LH, FN_LHU, FN_LB: begin
          r.mem_request = MEM_LOAD;
          r.mem_address = a + imm;
          r.mem_bytes = (op.func == FN_LW) ? SIZE_WORD : (op.func == FN_LB) ? SIZE_BYTE :
                        SIZE_HALF;
          r.mem_unsigned = (op.func == FN_LHU);
        end
        FN_SW: begin
          r.mem_request = MEM_STORE;
          r.mem_address = a + imm;
          r.mem_bytes = SIZE_WORD;
          r.store_data = b;
        end
        FN_SH: begin
          r.mem_request = MEM_STORE;
          r.mem_address = a + imm;
          r.mem_bytes = SIZE_HALF;
          r.store_data = {16'h0000, b[15:0]};
        end
        FN_SB: begin
          r.mem_request = MEM_STORE;
          r.mem_address = a + imm;
          r.mem_bytes = SIZE_BYTE;
          r.store_data = {24'h000000, b[7:0]};
        end
        FN_JAL: begin
          wval = pc + INSN_BYTES;
          r.next_pc = pc + imm;
        end
        FN_JALR: begin
          wval = pc + INSN_BYTES;
          r.next_pc = (a + imm) & ~32'd1;
        end
        FN_BEQ:  taken = (a == b);
        FN_BNE:  taken = (a != b);
        FN_BLT:  taken = ($signed(a) < $signed(b));
        FN_BLTU: taken = (a < b);
        FN_BGE:  taken = !($signed(a) < $signed(b));
        FN_BGEU: taken = !(a < b);
        FN_ECALL, FN_EBRK, FN_CSRRW: ;
        default: r.status = 1'b1;
      endcase
      if (op.func <= FN_AUIPC || op.func == FN_JAL || op.func == FN_JALR) begin
        r.write_value = wval;
        r.write_enable = 1'b1;
        r.writeback_needed = 1'b1;
      end else if (op.func >= FN_BEQ && op.func <= FN_BGEU) begin
        r.writeback_needed = 1'b1;
        if (taken) r.next_pc = pc + imm;
      end
      return r;
    endfunction

    function void note_item(lane_op_t op);
      expected_q.push_back(execute_lane(op));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, field, got, want);
      mismatches++;
    endtask

    task compare_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(field, got, want);
    endtask

    task check_result(lane_result_t got);
      lane_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result beat", got.next_pc, '0);
      end else begin
        want = expected_q.pop_front();
        compare_field("write_value", got.write_value, want.write_value);
        compare_field("write_enable", 32'(got.write_enable), 32'(want.write_enable));
        compare_field("write_index", 32'(got.write_index), 32'(want.write_index));
        compare_field("next_pc", got.next_pc, want.next_pc);
        compare_field("mem_request", 32'(got.mem_request), 32'(want.mem_request));
        compare_field("mem_address", got.mem_address, want.mem_address);
        compare_field("mem_bytes", 32'(got.mem_bytes), 32'(want.mem_bytes));
        compare_field("mem_unsigned", 32'(got.mem_unsigned), 32'(want.mem_unsigned));
        compare_field("store_data", got.store_data, want.store_data);
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("writeback_needed", 32'(got.writeback_needed),
                      32'(want.writeback_needed));
        compare_field("last_out", 32'(got.last_out), 32'(want.last_out));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [5:0]         func = '0;
  logic signed [31:0] first_value = '0;
  logic signed [31:0] second_value = '0;
  logic signed [31:0] immediate = '0;
  logic [31:0]        lane_pc = '0;
  logic [4:0]         dest_index = '0;
  logic               last_lane = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [31:0]        write_value;
  logic               write_enable;
  logic [4:0]         write_index;
  logic [31:0]        next_pc;
  logic [1:0]         mem_request;
  logic [31:0]        mem_address;
  logic [2:0]         mem_bytes;
  logic               mem_unsigned;
  logic [31:0]        store_data;
  logic               status;
  logic               writeback_needed;
  logic               last_out;

  logic        calm = 1'b0;
  int unsigned cycles = 0;
  lane_scoreboard lane_sb = new();
  logic [31:0] corner_words[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  simt_lane_rv32i_execute i_dut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .func             (func),
    .first_value      (first_value),
    .second_value     (second_value),
    .immediate        (immediate),
    .lane_pc          (lane_pc),
    .dest_index       (dest_index),
    .last_lane        (last_lane),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .write_value      (write_value),
    .write_enable     (write_enable),
    .write_index      (write_index),
    .next_pc          (next_pc),
    .mem_request      (mem_request),
    .mem_address      (mem_address),
    .mem_bytes        (mem_bytes),
    .mem_unsigned     (mem_unsigned),
    .store_data       (store_data),
    .status           (status),
    .writeback_needed (writeback_needed),
    .last_out         (last_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= !calm && ($urandom_range(99) < 17);
  end

  // Both channels are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      lane_sb.note_item({func, first_value, second_value, immediate, lane_pc, dest_index,
                         last_lane});
    end
    if (!rst && result_valid && !result_stall) begin
      lane_sb.check_result({write_value, write_enable, write_index, next_pc, mem_request,
                            mem_address, mem_bytes, mem_unsigned, store_data, status,
                            writeback_needed, last_out});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic lane_op_t make_op(logic [5:0] code, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] imm, logic [31:0] pc, logic [4:0] rd,
                                       logic last);
    lane_op_t op;
    op = {code, a, b, imm, pc, rd, last};
    return op;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    case ($urandom_range(9))
      0, 1:    w = $urandom_range(16) - 8;
      2:       w = corner_words[2'($urandom_range(3))];
      3:       w = $urandom_range(63);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_item(lane_op_t op);
    while (!calm && $urandom_range(99) < 17) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    func <= op.func;
    first_value <= op.first_value;
    second_value <= op.second_value;
    immediate <= op.immediate;
    lane_pc <= op.lane_pc;
    dest_index <= op.dest_index;
    last_lane <= op.last_lane;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  initial begin
    lane_op_t op;
    logic [5:0] code;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every operation once with corner operands, then the unsupported extremes.
    for (int k = 0; k <= FN_CSRRW + 2; k++) begin
      code = (k == FN_CSRRW + 2) ? FN_MAX : 6'(k);
      send_item(make_op(code, corner_words[2'(k % 4)], corner_words[2'((k + 1) % 4)],
                        corner_words[2'((k + 2) % 4)], corner_words[2'((k + 3) % 4)],
                        5'(k), k[0]));
    end
    send_item(make_op(FN_SRAI, 32'h8000_0000, 32'h0, 32'hFFFF_FFE4, 32'h0000_1000, 5'd31,
                      1'b1));
    send_item(make_op(FN_SRL, 32'h8000_0001, 32'h0000_0023, 32'h0, 32'h0, 5'd0, 1'b0));
    send_item(make_op(FN_JALR, 32'h0000_1001, 32'h0, 32'h0000_0002, 32'hFFFF_FFFC, 5'd1,
                      1'b0));
    send_item(make_op(FN_BLT, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFF0, 32'h100, 5'd2, 1'b0));
    send_item(make_op(FN_BLTU, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFF0, 32'h100, 5'd3, 1'b1));
    send_item(make_op(FN_BGE, 32'h1234_5678, 32'h1234_5678, 32'h8, 32'h200, 5'd4, 1'b0));

    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= 400 && n < 600);
      if ($urandom_range(99) < 12) begin
        op.func = 6'($urandom_range(FN_MAX, FN_FIRST_UNSUPPORTED));
      end else begin
        op.func = 6'($urandom_range(FN_CSRRW));
      end
      op.first_value = pick_operand();
      op.second_value = ($urandom_range(4) == 0) ? op.first_value : pick_operand();
      op.immediate = pick_operand();
      op.lane_pc = ($urandom_range(9) == 0) ? pick_operand() : $urandom;
      op.dest_index = 5'($urandom_range(31));
      op.last_lane = 1'($urandom_range(1));
      send_item(op);
    end
    calm = 1'b0;
    item_valid <= 1'b0;
    @(posedge clk);
    while (lane_sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (lane_sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_decode.sv
hw/rtl/sle_alu.sv
hw/rtl/simt_lane_rv32i_execute.sv
hw/rtl/sle_checker.sv
verif/simt_lane_rv32i_execute_tb.sv
